@@ rtl/vau_pkg.sv @@
// Shared constants, types and the arctangent table of the vector angle unit.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package vau_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 18;
  localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

  // internal angle format: Q60
  localparam int QBITS    = 60;
  localparam int TAB_SIZE = 32;
  localparam int STEP_W   = $clog2(TAB_SIZE);
  localparam int CELL_COUNT = (CORDIC_STEPS < TAB_SIZE) ? CORDIC_STEPS : TAB_SIZE;

  // scaled atan2 arguments stay within 2^58; the rotated x grows by about 1.65 * sqrt(2)
  localparam int SW     = 60;
  localparam int XW     = 62;
  localparam int ZW     = 64;
  localparam int PROD_W = 2 * COORD_WIDTH;

  localparam int SCALE_D   = 59 - 2 * COORD_WIDTH;
  localparam int SCALE_SHL = (SCALE_D >= 0) ? SCALE_D : 0;
  localparam int SCALE_SHR = (SCALE_D < 0) ? -SCALE_D : 0;

  localparam int S_DATA_W = ((4 * COORD_WIDTH + 7) / 8) * 8;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = ((ANGLE_WIDTH + 7) / 8) * 8;
  localparam int M_USER_W = 1;

  localparam logic [1:0] CMD_POLAR    = 2'd0;
  localparam logic [1:0] CMD_DIRECTED = 2'd1;
  localparam logic [1:0] CMD_LINE     = 2'd2;

  typedef logic signed [ZW-1:0] angle_q_t;
  typedef angle_q_t atan_tab_t [TAB_SIZE];

  // unsigned long division for building the table at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 from the truncated series, terms floor(2^(60-i(2k+1)) / (2k+1))
  function automatic angle_q_t atan_pow2(input int i);
    logic [63:0] t;
    angle_q_t    sum;
    int          e;
    int          lim_e;
    sum   = '0;
    lim_e = QBITS - 2 * i;
    for (int k = 0; k < 64; k++) begin
      e = QBITS - i * (2 * k + 1);
      if (e < 0) begin
        t = '0;
      end else begin
        t = udiv64(64'd1 << e, 64'(2 * k + 1));
      end
      if (t == 64'd0) break;
      if ((k & 1) != 0) begin
        sum = sum - $signed(t);
      end else begin
        sum = sum + $signed(t);
      end
      if (i * (2 * k + 1) > lim_e) break;
    end
    return sum;
  endfunction

  // atan(1/3) in Q60 from the same truncated series
  function automatic angle_q_t atan_third();
    logic [63:0] one;
    logic [63:0] lim;
    logic [63:0] pw;
    logic [63:0] t;
    angle_q_t    sum;
    one = 64'd1 << QBITS;
    lim = udiv64(one, 64'd9);
    pw  = 64'd3;
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      t = udiv64(udiv64(one, pw), 64'(2 * k + 1));
      if (t == 64'd0) break;
      if ((k & 1) != 0) begin
        sum = sum - $signed(t);
      end else begin
        sum = sum + $signed(t);
      end
      if (pw > lim) break;
      pw = pw * 64'd9;
    end
    return sum;
  endfunction

  function automatic atan_tab_t atan_table();
    atan_tab_t tab;
    tab[0] = atan_pow2(1) + atan_third();
    for (int i = 1; i < TAB_SIZE; i++) begin
      tab[i] = atan_pow2(i);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = atan_table();

  localparam angle_q_t PI_Q      = ATAN_TAB[0] <<< 2;
  localparam angle_q_t PI_HALF_Q = PI_Q >>> 1;
  localparam angle_q_t TWO_PI_Q  = PI_Q <<< 1;

  localparam int       ROUND_SH   = QBITS - ANGLE_FRAC_BITS;
  localparam angle_q_t ROUND_HALF = angle_q_t'(1) <<< (ROUND_SH - 1);
  localparam angle_q_t ROUND_FULL = (TWO_PI_Q + ROUND_HALF) >>> ROUND_SH;

  // one beat moving down the rotation chain
  typedef struct packed {
    logic [1:0]           cmd;
    logic                 zero;
    logic                 hold;   // angle already final, skip rotations
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    angle_q_t             z;
  } cordic_t;

endpackage

`default_nettype wire

@@ rtl/vector_angle_unit.sv @@
// Vector angle unit: front end, a chain of CORDIC rotation cells, back end.
// Each rotation cell is one pipeline stage.
// Throughput: one beat per cycle; each stage holds its own valid bit, so a
// stalled output only stops the stages behind it once they are all full.
// Reset (rst, synchronous) clears every valid bit; payload registers are not reset.
// Depends on vau_pkg, vau_prep, vau_cell and vau_post.
`default_nettype none

module vector_angle_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [vau_pkg::S_DATA_W-1:0]   s_tdata,  // ax, ay, bx, by
  input  logic [vau_pkg::S_USER_W-1:0]   s_tuser,  // command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [vau_pkg::M_DATA_W-1:0]   m_tdata,  // angle, zero fill
  output logic [vau_pkg::M_USER_W-1:0]   m_tuser   // zero_input
);

  localparam int CW = vau_pkg::COORD_WIDTH;
  localparam int NC = vau_pkg::CELL_COUNT;

  logic             chain_valid [NC+1];
  logic             chain_ready [NC+1];
  vau_pkg::cordic_t chain_data  [NC+1];

  logic [vau_pkg::ANGLE_WIDTH-1:0] angle;
  logic                            zero_input;

  vau_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (s_tuser[1:0]),
    .ax        (s_tdata[CW-1:0]),
    .ay        (s_tdata[2*CW-1:CW]),
    .bx        (s_tdata[3*CW-1:2*CW]),
    .by        (s_tdata[4*CW-1:3*CW]),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  for (genvar k = 0; k < NC; k++) begin : g_cell
    vau_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (vau_pkg::STEP_W'(k)),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  vau_post u_post (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chain_valid[NC]),
    .in_ready   (chain_ready[NC]),
    .in_data    (chain_data[NC]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .angle      (angle),
    .zero_input (zero_input)
  );

  assign m_tdata = vau_pkg::M_DATA_W'(angle);
  assign m_tuser = vau_pkg::M_USER_W'(zero_input);

  // input side only backs up when the output beat is held
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a held output beat");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && zero_input) |-> (angle == '0))
    else $error("zero argument beat carries a nonzero angle");

  a_below_turn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (vau_pkg::ZW'(angle) < vau_pkg::ROUND_FULL))
    else $error("angle reached a full turn");

endmodule

`default_nettype wire

@@ rtl/vau_prep.sv @@
// Front end of the vector angle unit: products, cross and dot, axis and
// half-plane handling. Three pipeline stages. Depends on vau_pkg.
`default_nettype none

module vau_prep (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            cmd,
  input  logic signed [vau_pkg::COORD_WIDTH-1:0] ax,
  input  logic signed [vau_pkg::COORD_WIDTH-1:0] ay,
  input  logic signed [vau_pkg::COORD_WIDTH-1:0] bx,
  input  logic signed [vau_pkg::COORD_WIDTH-1:0] by,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output vau_pkg::cordic_t                      out_data
);

  typedef struct packed {
    logic [1:0]                          cmd;
    logic signed [vau_pkg::PROD_W-1:0]   p_ax_by;
    logic signed [vau_pkg::PROD_W-1:0]   p_ay_bx;
    logic signed [vau_pkg::PROD_W-1:0]   p_ax_bx;
    logic signed [vau_pkg::PROD_W-1:0]   p_ay_by;
  } prod_t;

  typedef struct packed {
    logic [1:0]                    cmd;
    logic signed [vau_pkg::SW-1:0] cr;
    logic signed [vau_pkg::SW-1:0] dt;
  } arg_t;

  function automatic logic signed [vau_pkg::SW-1:0] scale(
    input logic signed [vau_pkg::PROD_W-1:0] p
  );
    logic signed [63:0] e;
    e = 64'(p);
    e = (e <<< vau_pkg::SCALE_SHL) >>> vau_pkg::SCALE_SHR;
    return vau_pkg::SW'(e);
  endfunction

  logic  v1, v2, v3;
  logic  rdy1, rdy2, rdy3;
  prod_t s1, s1_next;
  arg_t  s2, s2_next;
  vau_pkg::cordic_t s3_next;

  logic signed [vau_pkg::COORD_WIDTH-1:0] ua, va, ub, vb;
  logic signed [vau_pkg::XW-1:0] ex, ey;
  logic cmd_known;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  // polar angle is the directed angle from (1,0) to a
  always_comb begin
    if (cmd == vau_pkg::CMD_POLAR) begin
      ua = vau_pkg::COORD_WIDTH'(1);
      va = '0;
      ub = ax;
      vb = ay;
    end else begin
      ua = ax;
      va = ay;
      ub = bx;
      vb = by;
    end
    s1_next.cmd     = cmd;
    s1_next.p_ax_by = ua * vb;
    s1_next.p_ay_bx = va * ub;
    s1_next.p_ax_bx = ua * ub;
    s1_next.p_ay_by = va * vb;
  end

  always_comb begin
    s2_next.cmd = s1.cmd;
    s2_next.cr  = scale(s1.p_ax_by) - scale(s1.p_ay_bx);
    s2_next.dt  = scale(s1.p_ax_bx) + scale(s1.p_ay_by);
  end

  always_comb begin
    ex = vau_pkg::XW'(s2.dt);
    ey = vau_pkg::XW'(s2.cr);
    cmd_known = (s2.cmd == vau_pkg::CMD_POLAR) || (s2.cmd == vau_pkg::CMD_DIRECTED) ||
                (s2.cmd == vau_pkg::CMD_LINE);
    s3_next.cmd  = s2.cmd;
    s3_next.zero = 1'b0;
    s3_next.hold = 1'b1;
    s3_next.x    = ex;
    s3_next.y    = ey;
    s3_next.z    = '0;
    priority if (!cmd_known) begin
      s3_next.z = '0;
    end else if (ey == '0 && ex == '0) begin
      s3_next.zero = 1'b1;
    end else if (ey == '0) begin
      s3_next.z = ex[vau_pkg::XW-1] ? vau_pkg::PI_Q : '0;
    end else if (ex == '0) begin
      s3_next.z = ey[vau_pkg::XW-1] ? -vau_pkg::PI_HALF_Q : vau_pkg::PI_HALF_Q;
    end else if (ex[vau_pkg::XW-1]) begin
      // left half plane: mirror through the origin and carry +/- pi
      s3_next.hold = 1'b0;
      s3_next.x    = -ex;
      s3_next.y    = -ey;
      s3_next.z    = ey[vau_pkg::XW-1] ? -vau_pkg::PI_Q : vau_pkg::PI_Q;
    end else begin
      s3_next.hold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= s1_next;
    if (rdy2) s2 <= s2_next;
    if (rdy3) out_data <= s3_next;
  end

endmodule

`default_nettype wire

@@ rtl/vau_cell.sv @@
// One vectoring CORDIC rotation cell with its own pipeline register.
// The step input is tied to a constant per cell. Depends on vau_pkg.
`default_nettype none

module vau_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [vau_pkg::STEP_W-1:0]  step,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  vau_pkg::cordic_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output vau_pkg::cordic_t            out_data
);

  vau_pkg::cordic_t data_next;
  logic signed [vau_pkg::XW-1:0] xs, ys;
  vau_pkg::angle_q_t rot;
  logic v;

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  always_comb begin
    xs  = in_data.x >>> step;
    ys  = in_data.y >>> step;
    rot = vau_pkg::ATAN_TAB[step];
    data_next = in_data;
    if (!in_data.hold) begin
      // y at or above zero: rotate clockwise
      if (!in_data.y[vau_pkg::XW-1]) begin
        data_next.x = in_data.x + ys;
        data_next.y = in_data.y - xs;
        data_next.z = in_data.z + rot;
      end else begin
        data_next.x = in_data.x - ys;
        data_next.y = in_data.y + xs;
        data_next.z = in_data.z - rot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) out_data <= data_next;
  end

endmodule

`default_nettype wire

@@ rtl/vau_post.sv @@
// Back end of the vector angle unit: range wrap, line-angle folding,
// rounding to the output format and saturation. Depends on vau_pkg.
`default_nettype none

module vau_post (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vau_pkg::cordic_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vau_pkg::ANGLE_WIDTH-1:0]   angle,
  output logic                              zero_input
);

  typedef struct packed {
    logic              is_line;
    logic              zero;
    vau_pkg::angle_q_t t;
  } wrap_t;

  logic  v1, v2, v3;
  logic  rdy1, rdy2, rdy3;
  wrap_t s1, s1_next, s2, s2_next;
  vau_pkg::angle_q_t flip, tr, r;
  logic [vau_pkg::ANGLE_WIDTH-1:0] angle_next;

  assign rdy3      = !v3 || out_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;

  always_comb begin
    s1_next.is_line = (in_data.cmd == vau_pkg::CMD_LINE);
    s1_next.zero    = in_data.zero;
    s1_next.t       = in_data.z;
    if (in_data.z[vau_pkg::ZW-1]) begin
      s1_next.t = in_data.z + (s1_next.is_line ? vau_pkg::PI_Q : vau_pkg::TWO_PI_Q);
    end
  end

  // line angles only: outside [0, pi] becomes zero, then the obtuse side folds back below pi/2
  always_comb begin
    flip    = vau_pkg::PI_Q - s1.t;
    s2_next = s1;
    if (s1.is_line) begin
      priority if (s1.t[vau_pkg::ZW-1]) begin
        s2_next.t = '0;
      end else if (s1.t > vau_pkg::PI_Q) begin
        s2_next.t = '0;
      end else if (s1.t > vau_pkg::PI_HALF_Q) begin
        s2_next.t = flip;
      end else begin
        s2_next.t = s1.t;
      end
    end
  end

  always_comb begin
    tr = s2.t + vau_pkg::ROUND_HALF;
    r  = tr >>> vau_pkg::ROUND_SH;
    priority if (r >= vau_pkg::ROUND_FULL) begin
      angle_next = vau_pkg::ANGLE_WIDTH'(vau_pkg::ROUND_FULL - vau_pkg::angle_q_t'(1));
    end else if (r[vau_pkg::ZW-1]) begin
      angle_next = '0;
    end else begin
      angle_next = vau_pkg::ANGLE_WIDTH'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= s1_next;
    if (rdy2) s2 <= s2_next;
    if (rdy3) begin
      angle      <= angle_next;
      zero_input <= s2.zero;
    end
  end

endmodule

`default_nettype wire
